[hdl/btf_pkg.sv]
// ----------------------------------------------------------------------------
// Blob track filter package
// Shared types and constants for the track table cells and the control.
// ----------------------------------------------------------------------------
package btf_pkg;

  localparam int LIMIT_ENTRIES = 6;
  localparam int SEEN_STEP = 15;
  localparam logic [7:0] SEEN_MAX = 8'd255;
  localparam logic [5:0] MISS_MAX = 6'd63;

  localparam logic [5:0] MISS_LIMIT [LIMIT_ENTRIES] =
    '{6'd10, 6'd15, 6'd25, 6'd35, 6'd45, 6'd60};

  localparam logic REG_MATCH_BOX      = 1'b0;
  localparam logic REG_CONFIRM_FRAMES = 1'b1;

  localparam logic MODE_KEYPOINT = 1'b0;
  localparam logic MODE_EOF      = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_COMPACT
  } state_t;

  typedef struct packed {
    logic eval;
    logic hit_upd;
    logic append;
    logic age;
    logic shift;
  } cell_ctl_t;

  typedef struct packed {
    logic       valid;
    logic       matched;
    logic       confirmed;
    logic       drop;
    logic       hit;
    logic [7:0] seen;
    logic [5:0] miss;
  } cell_stat_t;

endpackage

[hdl/blob_track_temporal_filter_top.sv]
// ----------------------------------------------------------------------------
// Blob track temporal filter
// Ordered table of tracked blob centres, built as a row of entry cells.
//
//   Channel   Handshake                 Payload
//   item      item_valid / item_stall   mode, pos_x, pos_y
//   result    res_valid / res_stall     slot, is_new, is_confirmed, dropped,
//                                       live_tracks, removed_tracks
//   config    cfg_valid / cfg_ready     cfg_index, cfg_data
//
// For a keypoint, all cells compare in the accept cycle and the chosen cell
// is updated in the update state. An end of frame ages the entries in the
// accept cycle; the row then closes one gap per cycle by handing entries down
// to the neighbouring cell. Reset empties the table at once.
// A stalled result holds the final step until the result register is free.
// ----------------------------------------------------------------------------
module blob_track_temporal_filter_top #(
  parameter int TRACK_SLOTS = 16,
  parameter int COORD_BITS  = 12
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_stall,
  input  logic                  mode,
  input  logic [COORD_BITS-1:0] pos_x,
  input  logic [COORD_BITS-1:0] pos_y,
  output logic                  res_valid,
  input  logic                  res_stall,
  output logic [3:0]            slot,
  output logic                  is_new,
  output logic                  is_confirmed,
  output logic                  dropped,
  output logic [4:0]            live_tracks,
  output logic [4:0]            removed_tracks,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic                  cfg_index,
  input  logic [7:0]            cfg_data
);
  import btf_pkg::*;

  localparam int IW = (TRACK_SLOTS > 1) ? $clog2(TRACK_SLOTS) : 1;
  localparam int CW = $clog2(TRACK_SLOTS + 1);

  state_t state;
  state_t state_next;

  logic [7:0]            match_box;
  logic [7:0]            confirm_frames;
  logic [COORD_BITS-1:0] kp_x;
  logic [COORD_BITS-1:0] kp_y;
  logic [CW-1:0]         count;
  logic [CW-1:0]         count_next;
  logic [CW-1:0]         removed;
  logic [CW-1:0]         removed_next;

  logic [COORD_BITS-1:0] bus_x;
  logic [COORD_BITS-1:0] bus_y;
  cell_ctl_t             ctl [TRACK_SLOTS];
  cell_stat_t            stat [TRACK_SLOTS];
  logic [COORD_BITS-1:0] ent_x [TRACK_SLOTS];
  logic [COORD_BITS-1:0] ent_y [TRACK_SLOTS];
  logic [TRACK_SLOTS-1:0] conf_vec;
  logic [TRACK_SLOTS-1:0] hit_vec;
  logic [TRACK_SLOTS-1:0] drop_vec;
  logic [TRACK_SLOTS-1:0] valid_vec;
  logic [TRACK_SLOTS-1:0] upd_vec;

  logic          accept;
  logic          res_free;
  logic          hit_any;
  logic [IW-1:0] hit_idx;
  logic          drop_any;
  logic [IW-1:0] drop_idx;
  logic          do_eval;
  logic          do_age;
  logic          do_hit;
  logic          do_append;
  logic          do_shift;
  logic          res_load;
  logic [3:0]    slot_next;
  logic          is_new_next;
  logic          is_confirmed_next;
  logic          dropped_next;
  logic [4:0]    live_next;
  logic [4:0]    removed_out_next;

  assign item_stall = (state != ST_IDLE);
  assign accept     = item_valid && !item_stall;
  assign res_free   = !res_valid || !res_stall;
  assign cfg_ready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      match_box      <= 8'd20;
      confirm_frames <= 8'd5;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MATCH_BOX:      match_box      <= cfg_data;
        REG_CONFIRM_FRAMES: confirm_frames <= cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kp_x <= pos_x;
      kp_y <= pos_y;
    end
  end

  assign bus_x = (state == ST_IDLE) ? pos_x : kp_x;
  assign bus_y = (state == ST_IDLE) ? pos_y : kp_y;

  for (genvar k = 0; k < TRACK_SLOTS; k++) begin : g_cell
    cell_stat_t            nb_stat;
    logic [COORD_BITS-1:0] nb_x;
    logic [COORD_BITS-1:0] nb_y;

    if (k == TRACK_SLOTS - 1) begin : g_last
      assign nb_stat = '0;
      assign nb_x    = '0;
      assign nb_y    = '0;
    end else begin : g_inner
      assign nb_stat = stat[k+1];
      assign nb_x    = ent_x[k+1];
      assign nb_y    = ent_y[k+1];
    end

    btf_cell #(
      .COORD_BITS(COORD_BITS)
    ) u_cell (
      .clk           (clk),
      .rst           (rst),
      .ctl           (ctl[k]),
      .match_box     (match_box),
      .confirm_frames(confirm_frames),
      .pos_x         (bus_x),
      .pos_y         (bus_y),
      .nb_stat       (nb_stat),
      .nb_x          (nb_x),
      .nb_y          (nb_y),
      .stat          (stat[k]),
      .ent_x         (ent_x[k]),
      .ent_y         (ent_y[k]),
      .confirm_if_hit(conf_vec[k])
    );

    assign hit_vec[k]   = stat[k].hit;
    assign drop_vec[k]  = stat[k].valid && stat[k].drop;
    assign valid_vec[k] = stat[k].valid;
  end

  always_comb begin
    hit_any  = 1'b0;
    hit_idx  = '0;
    drop_any = 1'b0;
    drop_idx = '0;
    for (int k = TRACK_SLOTS - 1; k >= 0; k--) begin
      if (hit_vec[k]) begin
        hit_any = 1'b1;
        hit_idx = IW'(k);
      end
      if (drop_vec[k]) begin
        drop_any = 1'b1;
        drop_idx = IW'(k);
      end
    end
  end

  always_comb begin
    state_next        = state;
    count_next        = count;
    removed_next      = removed;
    do_eval           = 1'b0;
    do_age            = 1'b0;
    do_hit            = 1'b0;
    do_append         = 1'b0;
    do_shift          = 1'b0;
    res_load          = 1'b0;
    slot_next         = 4'd0;
    is_new_next       = 1'b0;
    is_confirmed_next = 1'b0;
    dropped_next      = 1'b0;
    live_next         = 5'(count);
    removed_out_next  = 5'd0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (mode == MODE_EOF) begin
            do_age       = 1'b1;
            removed_next = '0;
            state_next   = ST_COMPACT;
          end else begin
            do_eval    = 1'b1;
            state_next = ST_UPDATE;
          end
        end
      end
      ST_UPDATE: begin
        if (res_free) begin
          res_load   = 1'b1;
          state_next = ST_IDLE;
          if (hit_any) begin
            do_hit            = 1'b1;
            slot_next         = 4'(hit_idx);
            is_confirmed_next = conf_vec[hit_idx];
          end else if (count < CW'(TRACK_SLOTS)) begin
            do_append   = 1'b1;
            count_next  = count + CW'(1);
            slot_next   = 4'(count);
            is_new_next = 1'b1;
            live_next   = 5'(count + CW'(1));
          end else begin
            dropped_next = 1'b1;
          end
        end
      end
      ST_COMPACT: begin
        if (drop_any) begin
          do_shift     = 1'b1;
          count_next   = count - CW'(1);
          removed_next = removed + CW'(1);
        end else if (res_free) begin
          res_load         = 1'b1;
          removed_out_next = 5'(removed);
          state_next       = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    for (int k = 0; k < TRACK_SLOTS; k++) begin
      ctl[k].eval    = do_eval;
      ctl[k].age     = do_age;
      ctl[k].hit_upd = do_hit && (hit_idx == IW'(k));
      ctl[k].append  = do_append && (count[IW-1:0] == IW'(k));
      ctl[k].shift   = do_shift && (IW'(k) >= drop_idx);
      upd_vec[k]     = ctl[k].hit_upd || ctl[k].append;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      count   <= '0;
      removed <= '0;
    end else begin
      state   <= state_next;
      count   <= count_next;
      removed <= removed_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      slot           <= slot_next;
      is_new         <= is_new_next;
      is_confirmed   <= is_confirmed_next;
      dropped        <= dropped_next;
      live_tracks    <= live_next;
      removed_tracks <= removed_out_next;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(TRACK_SLOTS))
    else $error("live count exceeds the table size");

  a_table_packed: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> ($countones(valid_vec) == int'(count)))
    else $error("valid entries disagree with the live count");

  a_single_update: assert property (@(posedge clk) disable iff (rst)
    $onehot0(upd_vec))
    else $error("more than one cell updated by a keypoint");

  a_result_kind: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !(is_new && dropped))
    else $error("result both opens and drops an entry");

endmodule

[hdl/btf_cell.sv]
// ----------------------------------------------------------------------------
// Blob track filter cell
// Holds one table entry, compares it with a keypoint, ages it at the end of
// a frame and takes over its upper neighbour's entry while the table closes.
// ----------------------------------------------------------------------------
module btf_cell #(
  parameter int COORD_BITS = 12
) (
  input  logic                   clk,
  input  logic                   rst,
  input  btf_pkg::cell_ctl_t     ctl,
  input  logic [7:0]             match_box,
  input  logic [7:0]             confirm_frames,
  input  logic [COORD_BITS-1:0]  pos_x,
  input  logic [COORD_BITS-1:0]  pos_y,
  input  btf_pkg::cell_stat_t    nb_stat,
  input  logic [COORD_BITS-1:0]  nb_x,
  input  logic [COORD_BITS-1:0]  nb_y,
  output btf_pkg::cell_stat_t    stat,
  output logic [COORD_BITS-1:0]  ent_x,
  output logic [COORD_BITS-1:0]  ent_y,
  output logic                   confirm_if_hit
);
  import btf_pkg::*;

  localparam int DW = (COORD_BITS > 8) ? COORD_BITS : 8;

  logic                  valid;
  logic                  matched;
  logic                  confirmed;
  logic                  drop;
  logic                  hit;
  logic [7:0]            seen;
  logic [5:0]            miss;
  logic [COORD_BITS-1:0] x;
  logic [COORD_BITS-1:0] y;

  logic [COORD_BITS-1:0] dx;
  logic [COORD_BITS-1:0] dy;
  logic                  hit_next;
  logic [7:0]            seen_inc;
  logic [7:0]            seen_dec;
  logic [5:0]            miss_inc;
  logic [2:0]            sel;
  logic                  drop_next;

  always_comb begin
    dx = (pos_x > x) ? (pos_x - x) : (x - pos_x);
    dy = (pos_y > y) ? (pos_y - y) : (y - pos_y);
    hit_next = valid && !matched && (DW'(dx) < DW'(match_box)) &&
               (DW'(dy) < DW'(match_box));
    seen_inc = (seen == SEEN_MAX) ? seen : seen + 8'd1;
    seen_dec = (seen == 8'd0) ? seen : seen - 8'd1;
    miss_inc = (miss == MISS_MAX) ? miss : miss + 6'd1;
    confirm_if_hit = confirmed || (seen_inc > confirm_frames);
  end

  always_comb begin
    sel = 3'd0;
    for (int j = 1; j < LIMIT_ENTRIES; j++) begin
      if (seen_dec >= 8'(j * SEEN_STEP)) begin
        sel = sel + 3'd1;
      end
    end
    drop_next = valid && !matched && (miss_inc > MISS_LIMIT[sel]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid     <= 1'b0;
      matched   <= 1'b0;
      confirmed <= 1'b0;
      drop      <= 1'b0;
      hit       <= 1'b0;
    end else begin
      priority if (ctl.shift) begin
        valid     <= nb_stat.valid;
        matched   <= nb_stat.matched;
        confirmed <= nb_stat.confirmed;
        drop      <= nb_stat.drop;
        hit       <= nb_stat.hit;
      end else if (ctl.append) begin
        valid     <= 1'b1;
        matched   <= 1'b1;
        confirmed <= 1'b0;
        drop      <= 1'b0;
        hit       <= 1'b0;
      end else if (ctl.hit_upd) begin
        matched   <= 1'b1;
        confirmed <= confirm_if_hit;
        hit       <= 1'b0;
      end else if (ctl.age) begin
        matched   <= 1'b0;
        drop      <= drop_next;
        hit       <= 1'b0;
      end else begin
        hit       <= ctl.eval ? hit_next : hit;
      end
    end
  end

  always_ff @(posedge clk) begin
    priority if (ctl.shift) begin
      x    <= nb_x;
      y    <= nb_y;
      seen <= nb_stat.seen;
      miss <= nb_stat.miss;
    end else if (ctl.append) begin
      x    <= pos_x;
      y    <= pos_y;
      seen <= 8'd1;
      miss <= 6'd0;
    end else if (ctl.hit_upd) begin
      x    <= pos_x;
      y    <= pos_y;
      seen <= seen_inc;
      miss <= 6'd0;
    end else if (ctl.age && valid && !matched) begin
      seen <= seen_dec;
      miss <= miss_inc;
    end else begin
      seen <= seen;
      miss <= miss;
    end
  end

  always_comb begin
    stat.valid     = valid;
    stat.matched   = matched;
    stat.confirmed = confirmed;
    stat.drop      = drop;
    stat.hit       = hit;
    stat.seen      = seen;
    stat.miss      = miss;
    ent_x          = x;
    ent_y          = y;
  end

endmodule
